// File: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Operation codes, status codes, field widths and the queued item format.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned OccW   = 5;

  // mode field codes as they arrive on the input
  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [ModeW-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [ModeW-1:0] MODE_DUMP       = 3'd4;

  // decoded operation; count and unused modes both fold into OP_COUNT
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP,
    OP_COUNT
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                     done;
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [OccW-1:0]          occ;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// File: design/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/bdq_front.sv
// ----------------------------------------------------------------------------
// bdq_front: command intake of the bounded deque
// Decodes the mode and holds items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [bdq_pkg::ModeW-1:0]           mode_i,
  input  wire logic signed [bdq_pkg::ValueW-1:0]   push_value_i,
  output logic                                     busy_o,
  output logic                                     item_valid_o,
  output bdq_pkg::entry_t                          item_o,
  input  wire logic                                take_i
);

  import bdq_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  entry_t           slot_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]   fill_q, fill_d;
  logic             push, pop;
  op_e              op_dec;

  always_comb begin
    case (mode_i)
      MODE_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      MODE_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      MODE_POP_FRONT:  op_dec = OP_POP_FRONT;
      MODE_POP_BACK:   op_dec = OP_POP_BACK;
      MODE_DUMP:       op_dec = OP_DUMP;
      default:         op_dec = OP_COUNT;   // count and unused codes
    endcase
  end

  assign busy_o       = (fill_q == QCw'(QDepth));
  assign push         = start_i && !busy_o;
  assign item_valid_o = (fill_q != '0);
  assign pop          = item_valid_o && take_i;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
    end
    case ({push, pop})
      2'b10:   fill_d = fill_q + QCw'(1);
      2'b01:   fill_d = fill_q - QCw'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op_dec, value: push_value_i};
    end
  end

endmodule

`default_nettype wire

// File: design/bdq_back.sv
// ----------------------------------------------------------------------------
// bdq_back: execution end of the bounded deque
// Owns the ring store and pointers, runs one operation or one dump word a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  bdq_pkg::entry_t       item_i,
  output logic                  take_o,
  output bdq_pkg::result_t      result_o
);

  import bdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  typedef enum logic {
    S_RUN,
    S_DUMP
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    k_q, k_d;

  logic             res_vld_q, res_vld_d;
  logic             res_rd_q, res_rd_d;
  status_e          res_st_q, res_st_d;
  logic [OccW-1:0]  res_occ_q, res_occ_d;
  logic             res_last_q, res_last_d;

  logic [CW-1:0]    ofs;
  logic [AW-1:0]    pos;
  logic             full, empty;
  logic             we, re;
  logic [AW-1:0]    waddr;
  logic [ValueW-1:0] rdata;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign take_o = item_valid_i && (state_q == S_RUN);

  always_comb begin
    ofs = '0;
    if (state_q == S_DUMP) begin
      ofs = k_q;
    end else begin
      case (item_i.op)
        OP_PUSH_BACK: ofs = count_q;
        OP_POP_BACK:  ofs = count_q - CW'(1);
        default:      ofs = '0;
      endcase
    end
  end

  assign pos = ring_pos(front_q, ofs);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    k_d        = k_q;
    we         = 1'b0;
    waddr      = pos;
    re         = 1'b0;
    res_vld_d  = 1'b0;
    res_rd_d   = 1'b0;
    res_st_d   = ST_OK;
    res_last_d = 1'b1;

    case (state_q)
      S_RUN: begin
        if (take_o) begin
          res_vld_d = 1'b1;
          case (item_i.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                waddr   = front_d;
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_st_d = ST_EMPTY;
              end else begin
                re       = 1'b1;
                res_rd_d = 1'b1;
                front_d  = ring_pos(front_q, CW'(1));
                count_d  = count_q - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_st_d = ST_EMPTY;
              end else begin
                re       = 1'b1;
                res_rd_d = 1'b1;
                count_d  = count_q - CW'(1);
              end
            end
            OP_DUMP: begin
              if (empty) begin
                res_st_d = ST_EMPTY;
              end else begin
                re         = 1'b1;
                res_rd_d   = 1'b1;
                res_last_d = (count_q == CW'(1));
                if (count_q != CW'(1)) begin
                  state_d = S_DUMP;
                  k_d     = CW'(1);
                end
              end
            end
            default: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        re         = 1'b1;
        res_vld_d  = 1'b1;
        res_rd_d   = 1'b1;
        res_last_d = (k_q == count_q - CW'(1));
        if (res_last_d) begin
          state_d = S_RUN;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase

    res_occ_d = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RUN;
      front_q    <= '0;
      count_q    <= '0;
      k_q        <= '0;
      res_vld_q  <= 1'b0;
      res_rd_q   <= 1'b0;
      res_st_q   <= ST_OK;
      res_occ_q  <= '0;
      res_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      k_q        <= k_d;
      res_vld_q  <= res_vld_d;
      res_rd_q   <= res_rd_d;
      res_st_q   <= res_st_d;
      res_occ_q  <= res_occ_d;
      res_last_q <= res_last_d;
    end
  end

  bdq_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.value),
    .re_i    (re),
    .raddr_i (pos),
    .rdata_o (rdata)
  );

  assign result_o.done   = res_vld_q;
  assign result_o.value  = res_rd_q ? $signed(rdata) : '0;
  assign result_o.status = res_st_q;
  assign result_o.occ    = res_occ_q;
  assign result_o.last   = res_last_q;

endmodule

`default_nettype wire

// File: design/bounded_deque_unit.sv
// Result path: an item waits in the front-end queue until the back end takes it;
//   its result leaves registered, after any work queued ahead; no receiver stall.
// Throughput: one item per cycle for push, pop and count while no dump streams;
//   a dump holds the execution end over its stored words while the queue fills.
// Reset: asynchronous, active low; clears pointers, count and queue. Store
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// bounded_deque_unit: bounded double-ended queue of signed words
// Front end decodes commands into a short queue; back end owns the ring store.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [bdq_pkg::ModeW-1:0]           mode_i,
  input  wire logic signed [bdq_pkg::ValueW-1:0]   push_value_i,
  output logic                                     done_o,
  output logic signed [bdq_pkg::ValueW-1:0]        out_value_o,
  output logic [1:0]                               status_o,
  output logic [bdq_pkg::OccW-1:0]                 occupancy_o,
  output logic                                     last_o
);

  import bdq_pkg::*;

  // front end -> back end
  logic    item_valid;
  entry_t  item;
  logic    take;
  result_t result;

  // Front: accepts an item whenever its queue has room; busy_o is queue full.
  bdq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .busy_o       (busy_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  // Back: executes one item per cycle, or streams a dump word per cycle.
  // Results leave registered; the popped word comes straight off the RAM
  // read register.
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .result_o     (result)
  );

  assign done_o      = result.done;
  assign out_value_o = result.value;
  assign status_o    = result.status;
  assign occupancy_o = result.occ;
  assign last_o      = result.last;

  // full and empty results are always single-result, zero-valued
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> last_o && (out_value_o == '0))
    else $error("error result not final or not zero");

  // a dump streams without gaps until its back word
  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o)
    else $error("dump stream broke before last word");

  // a non-final result is a dump word, so it is ok status
  a_dump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> status_o == ST_OK)
    else $error("non-final result with error status");

  // occupancy never drops during a dump stream
  a_dump_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> occupancy_o == $past(occupancy_o))
    else $error("occupancy changed inside a dump");

endmodule

`default_nettype wire

// File: tb/sv/tb_bounded_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_unit: self-checking bench for the bounded deque
// Items go in through the start/busy command port. A shadow deque in the
// bench predicts every result. A checker compares each strobed result with
// the oldest prediction. Directed corner cases run first, then random
// traffic that swings between filling and draining under several idle rates.
// ----------------------------------------------------------------------------

module tb_bounded_deque_unit;
  import bdq_pkg::*;

  localparam int unsigned DEPTH = 16;

  // mode codes that the package leaves unnamed
  localparam logic [ModeW-1:0] MODE_COUNT    = 3'd5;
  localparam logic [ModeW-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNUSED_7 = 3'd7;

  localparam logic signed [ValueW-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] WORD_MAX = 32'sh7fff_ffff;

  // Slowest run: ~300 items, 87% sender idling, dumps of up to 16 words.
  // Even that run ends far below this limit, so it leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Covers the result path plus slack for a dump still streaming.
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [OccW-1:0]          occ;
    logic                     is_last;
  } deque_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [ModeW-1:0]          mode_i;
  logic signed [ValueW-1:0]  push_value_i;
  logic                      done_o;
  logic signed [ValueW-1:0]  out_value_o;
  logic [1:0]                status_o;
  logic [OccW-1:0]           occupancy_o;
  logic                      last_o;

  // Shadow copy of the deque, updated when an item is accepted.
  logic signed [ValueW-1:0]  shadow_words [DEPTH];
  int unsigned               shadow_front;
  int unsigned               shadow_count;

  // Results predicted but not yet seen on the output, oldest first.
  deque_result_t             awaited_results [$];
  deque_result_t             head_result;

  int unsigned               error_count;
  int unsigned               report_count;
  int unsigned               cycle_count;
  int unsigned               sender_idle_pct;
  int unsigned               items_sent;
  int unsigned               results_seen;
  int unsigned               full_rejects;
  int unsigned               empty_hits;
  int unsigned               dumped_words;

  bounded_deque_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .push_value_i(push_value_i),
    .done_o      (done_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited",
               $time, cycle_count, awaited_results.size());
      $display("tb_bounded_deque_unit: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Queue one expected result; occupancy is the shadow count at this point,
  // i.e. after the operation has been applied.
  function automatic void await_result(logic signed [ValueW-1:0] value,
                                       status_e status, logic is_last);
    deque_result_t r;
    r.value   = value;
    r.status  = status;
    r.occ     = shadow_count[OccW-1:0];
    r.is_last = is_last;
    awaited_results.push_back(r);
  endfunction

  // Apply one accepted item to the shadow deque and queue what it produces.
  function automatic void apply_deque_op(logic [ModeW-1:0] mode,
                                         logic signed [ValueW-1:0] value);
    logic signed [ValueW-1:0] taken;
    int unsigned              k;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          full_rejects++;
          await_result('0, ST_FULL, 1'b1);
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_words[shadow_front] = value;
          end else begin
            shadow_words[(shadow_front + shadow_count) % DEPTH] = value;
          end
          shadow_count++;
          await_result('0, ST_OK, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_count == 0) begin
          empty_hits++;
          await_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (mode == MODE_POP_FRONT) begin
            taken = shadow_words[shadow_front];
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            taken = shadow_words[(shadow_front + shadow_count - 1) % DEPTH];
          end
          shadow_count--;
          await_result(taken, ST_OK, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (shadow_count == 0) begin
          empty_hits++;
          await_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < shadow_count; k++) begin
            await_result(shadow_words[(shadow_front + k) % DEPTH], ST_OK,
                         (k + 1 == shadow_count));
          end
          dumped_words += shadow_count;
        end
      end
      // count and the unused modes leave the state alone
      default: await_result('0, ST_OK, 1'b1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void report_mismatch(string field, longint wanted, longint got);
    error_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, got);
    end
  endfunction

  // Results are never held off, so each strobe is checked on the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, value", 0, out_value_o);
      end else begin
        head_result = awaited_results.pop_front();
        if (out_value_o !== head_result.value)
          report_mismatch("out_value", head_result.value, out_value_o);
        if (status_o !== head_result.status)
          report_mismatch("status", head_result.status, status_o);
        if (occupancy_o !== head_result.occ)
          report_mismatch("occupancy", head_result.occ, occupancy_o);
        if (last_o !== head_result.is_last)
          report_mismatch("last", head_result.is_last, last_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Entered and left on a falling edge, so start_i gets one assignment per
  // step: a back-to-back item simply keeps it high.
  task automatic send_item(logic [ModeW-1:0] mode, logic signed [ValueW-1:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= mode;
    push_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted on this edge
    apply_deque_op(mode, value);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Words biased toward the extremes and the sign boundary.
  function automatic logic signed [ValueW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Pops, dump and count on an empty deque.
  task automatic test_empty_queue();
    send_item(MODE_POP_FRONT, pick_word());
    send_item(MODE_POP_BACK, pick_word());
    send_item(MODE_DUMP, pick_word());
    send_item(MODE_COUNT, pick_word());
  endtask

  // Extreme words through both ends, a dump, then drain to empty, dump it, and push and pop one word.
  task automatic test_extreme_words();
    send_item(MODE_PUSH_FRONT, WORD_MAX);   // front wraps below index zero
    send_item(MODE_PUSH_BACK, WORD_MIN);
    send_item(MODE_PUSH_FRONT, -1);
    send_item(MODE_PUSH_BACK, '0);
    send_item(MODE_DUMP, '0);
    send_item(MODE_POP_BACK, '0);
    send_item(MODE_POP_FRONT, '0);
    send_item(MODE_COUNT, '0);
    send_item(MODE_POP_BACK, '0);
    send_item(MODE_POP_FRONT, '0);          // removes the final word
    send_item(MODE_DUMP, '0);
    send_item(MODE_PUSH_BACK, 32'sh5a5a_a5a5);
    send_item(MODE_POP_FRONT, '0);
  endtask

  // Unused modes must act like count and leave the contents alone.
  task automatic test_unused_modes();
    send_item(MODE_PUSH_BACK, 32'sh1234_5678);
    send_item(MODE_UNUSED_6, WORD_MIN);
    send_item(MODE_UNUSED_7, -1);
    send_item(MODE_DUMP, '0);
    send_item(MODE_POP_BACK, '0);
  endtask

  // Random operations that alternate between a push-heavy and a pop-heavy
  // mix, so the deque repeatedly runs full and empty with random contents.
  task automatic test_random_traffic(int unsigned num_items, int unsigned idle_pct);
    logic             filling;
    int unsigned      r;
    int unsigned      n;
    logic [ModeW-1:0] mode;
    filling = (shadow_count < DEPTH / 2);
    sender_idle_pct = idle_pct;
    for (n = 0; n < num_items; n++) begin
      // flip direction only at the bound, and then by a one-in-three chance per item
      if (filling && shadow_count == DEPTH && $urandom_range(0, 2) == 0)
        filling = 1'b0;
      else if (!filling && shadow_count == 0 && $urandom_range(0, 2) == 0)
        filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 86) begin
        if (filling) begin
          if (r < 30)      mode = MODE_PUSH_FRONT;
          else if (r < 60) mode = MODE_PUSH_BACK;
          else if (r < 68) mode = MODE_POP_FRONT;
          else if (r < 76) mode = MODE_POP_BACK;
          else             mode = MODE_DUMP;
        end else begin
          if (r < 8)       mode = MODE_PUSH_FRONT;
          else if (r < 16) mode = MODE_PUSH_BACK;
          else if (r < 46) mode = MODE_POP_FRONT;
          else if (r < 76) mode = MODE_POP_BACK;
          else             mode = MODE_DUMP;
        end
      end else if (r < 94) begin
        mode = MODE_COUNT;
      end else begin
        mode = (r < 97) ? MODE_UNUSED_6 : MODE_UNUSED_7;
      end
      send_item(mode, pick_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = MODE_COUNT;
    push_value_i    = '0;
    shadow_front    = 0;
    shadow_count    = 0;
    error_count     = 0;
    report_count    = 0;
    cycle_count     = 0;
    items_sent      = 0;
    results_seen    = 0;
    full_rejects    = 0;
    empty_hits      = 0;
    dumped_words    = 0;
    sender_idle_pct = 38;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_extreme_words();
    test_unused_modes();

    // sender idles often, then almost always, then never
    test_random_traffic(90, 38);
    test_random_traffic(90, 87);
    test_random_traffic(90, 0);

    start_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    // catch any stray strobe after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results in %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Full pushes %0d, empty pops/dumps %0d, dumped words %0d, mismatches %0d.",
             full_rejects, empty_hits, dumped_words, error_count);
    if (error_count == 0) begin
      $display("tb_bounded_deque_unit: clean");
    end else begin
      $display("tb_bounded_deque_unit: errors");
    end
    $finish;
  end

endmodule
